[sv/cqa_pkg.sv]
// Shared types and constants for the checked Q16.16 arithmetic unit.
// Used by every module of the block; depends on nothing.
package cqa_pkg;

  localparam int DATA_W     = 32;
  localparam int WIDE_W     = 50;
  localparam int PROD_W     = 66;
  localparam int S_TDATA_W  = 96;
  localparam int S_TUSER_W  = 5;
  localparam int M_TDATA_W  = 48;
  localparam int M_TUSER_W  = 4;
  localparam int MILLI_W    = 10;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int DIV_STEPS  = 48;
  localparam int SQRT_STEPS = 24;
  localparam int CNT_W      = 6;
  localparam int ROOT_W     = 48;

  typedef enum logic [4:0] {
    OP_FROMINT    = 5'd0,
    OP_RATIO      = 5'd1,
    OP_TOINT      = 5'd2,
    OP_TOINTROUND = 5'd3,
    OP_PARTS      = 5'd4,
    OP_ADD        = 5'd5,
    OP_SUB        = 5'd6,
    OP_MUL        = 5'd7,
    OP_DIV        = 5'd8,
    OP_NEG        = 5'd9,
    OP_ABS        = 5'd10,
    OP_FLOOR      = 5'd11,
    OP_CEIL       = 5'd12,
    OP_ROUND      = 5'd13,
    OP_MIN        = 5'd14,
    OP_MAX        = 5'd15,
    OP_CLAMP      = 5'd16,
    OP_LERP       = 5'd17,
    OP_SQRT       = 5'd18
  } op_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_OVER   = 3'd1,
    ST_UNDER  = 3'd2,
    ST_DIVZ   = 3'd3,
    ST_RANGE  = 3'd4,
    ST_DOMAIN = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    KIND_PLAIN = 2'd0,
    KIND_MUL   = 2'd1,
    KIND_LERP  = 2'd2
  } kind_t;

  // One classified item as it waits in the queue.
  typedef struct packed {
    op_t                      op;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic signed [DATA_W-1:0] c;
    status_t                  st;
    logic                     iter;
  } item_t;

  // Start request to the divide / square root unit.
  typedef struct packed {
    logic                     go;
    logic                     take;
    logic                     is_sqrt;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
  } iter_req_t;

  // Status and result of the divide / square root unit.
  typedef struct packed {
    logic                     idle;
    logic                     done;
    logic signed [WIDE_W-1:0] value;
  } iter_res_t;

endpackage

[sv/checked_q16_16_fixed_alu.sv]
// Checked Q16.16 arithmetic unit: one result beat for every input beat.
// Results pass through the queue and the two back-end stages; div and ratio first run
// 48 quotient steps and sqrt 24 root steps in the shared iterative unit. Throughput:
// one beat per cycle while the receiver does not stall; divide and square root hold
// the queue head while the iterative unit runs. Reset clears queue and valids.
module checked_q16_16_fixed_alu (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [cqa_pkg::S_TDATA_W-1:0] s_tdata,  // operand_a [31:0], operand_b [63:32],
                                                  // operand_c [95:64]
  input  logic [cqa_pkg::S_TUSER_W-1:0] s_tuser,  // op [4:0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [cqa_pkg::M_TDATA_W-1:0] m_tdata,  // value [31:0], thousandths [41:32]
  output logic [cqa_pkg::M_TUSER_W-1:0] m_tuser   // status [2:0], is_negative [3]
);
  import cqa_pkg::*;

  item_t push_item;
  item_t head_item;
  logic  push, pop, full, head_valid;

  cqa_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (full),
    .q_push   (push),
    .q_item   (push_item)
  );

  cqa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  cqa_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule

[sv/cqa_front.sv]
// Front end: takes input beats and classifies them, flagging early errors.
// Depends on cqa_pkg.
module cqa_front (
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [cqa_pkg::S_TDATA_W-1:0]  s_tdata,  // a [31:0], b [63:32], c [95:64]
  input  logic [cqa_pkg::S_TUSER_W-1:0]  s_tuser,  // op [4:0]
  input  logic                           q_full,
  output logic                           q_push,
  output cqa_pkg::item_t                 q_item
);
  import cqa_pkg::*;

  logic signed [DATA_W-1:0] a;
  logic signed [DATA_W-1:0] b;
  logic signed [DATA_W-1:0] c;

  assign a = s_tdata[31:0];
  assign b = s_tdata[63:32];
  assign c = s_tdata[95:64];

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  // Operand checks that need no arithmetic result, and routing to the iterative unit.
  always_comb begin
    q_item.op   = op_t'(s_tuser[4:0]);
    q_item.a    = a;
    q_item.b    = b;
    q_item.c    = c;
    q_item.st   = ST_OK;
    q_item.iter = 1'b0;
    case (op_t'(s_tuser[4:0]))
      OP_FROMINT, OP_TOINT, OP_TOINTROUND, OP_PARTS, OP_ADD, OP_SUB, OP_MUL,
      OP_NEG, OP_ABS, OP_FLOOR, OP_CEIL, OP_ROUND, OP_MIN, OP_MAX: begin
        q_item.st = ST_OK;
      end
      OP_RATIO, OP_DIV: begin
        if (b == '0) q_item.st = ST_DIVZ;
        else q_item.iter = 1'b1;
      end
      OP_CLAMP: begin
        if (b > c) q_item.st = ST_RANGE;
      end
      OP_LERP: begin
        if (c < 0 || c > 32'sd65536) q_item.st = ST_RANGE;
      end
      OP_SQRT: begin
        if (a < 0) q_item.st = ST_DOMAIN;
        else q_item.iter = 1'b1;
      end
      default: begin
        q_item.st = ST_DOMAIN;
      end
    endcase
  end

endmodule

[sv/cqa_queue.sv]
// Short queue of classified items between the front and back ends.
// Depends on cqa_pkg.
module cqa_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cqa_pkg::item_t push_item,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output cqa_pkg::item_t head_item
);
  import cqa_pkg::*;

  item_t               mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full       = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = mem[rd_ptr];

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[sv/cqa_iter.sv]
// Shared iterative unit: restoring divide of |a|*65536 by |b|, one quotient bit
// a cycle, and a digit-by-digit square root of a*65536, one root bit a cycle.
// Depends on cqa_pkg.
module cqa_iter (
  input  logic               clk,
  input  logic               rst,
  input  cqa_pkg::iter_req_t req,
  output cqa_pkg::iter_res_t res
);
  import cqa_pkg::*;

  typedef enum logic [1:0] {IDLE, RUN, DONE} state_t;

  state_t             state;
  logic [CNT_W-1:0]   cnt;
  logic               is_sqrt;
  logic               q_neg;
  logic [32:0]        rem;
  logic [31:0]        den;
  logic [ROOT_W-1:0]  acc;
  logic [ROOT_W-1:0]  root;
  logic [ROOT_W-1:0]  sbit;

  logic [32:0]        rem_next;
  logic [ROOT_W-1:0]  acc_next;
  logic [ROOT_W-1:0]  root_next;
  logic [32:0]        shifted;
  logic [ROOT_W-1:0]  trial;
  logic [32:0]        mag_a;
  logic [32:0]        mag_b;

  assign mag_a = req.a[31] ? -{1'b1, req.a} : {1'b0, req.a};
  assign mag_b = req.b[31] ? -{1'b1, req.b} : {1'b0, req.b};

  // One step of the selected recurrence.
  always_comb begin
    shifted   = {rem[31:0], acc[ROOT_W-1]};
    trial     = root + sbit;
    rem_next  = rem;
    acc_next  = acc;
    root_next = root;
    if (is_sqrt) begin
      if (acc >= trial) begin
        acc_next  = acc - trial;
        root_next = (root >> 1) + sbit;
      end else begin
        root_next = root >> 1;
      end
    end else begin
      if (shifted >= {1'b0, den}) begin
        rem_next = shifted - {1'b0, den};
        acc_next = {acc[ROOT_W-2:0], 1'b1};
      end else begin
        rem_next = shifted;
        acc_next = {acc[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // Sequencer and data registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (req.go) begin
            state   <= RUN;
            is_sqrt <= req.is_sqrt;
            q_neg   <= req.a[31] ^ req.b[31];
            rem     <= '0;
            den     <= mag_b[31:0];
            root    <= '0;
            sbit    <= ROOT_W'(1) << (ROOT_W - 2);
            acc     <= {mag_a[31:0], 16'b0};
            cnt     <= req.is_sqrt ? CNT_W'(SQRT_STEPS - 1) : CNT_W'(DIV_STEPS - 1);
          end
        end
        RUN: begin
          rem  <= rem_next;
          acc  <= acc_next;
          root <= root_next;
          sbit <= sbit >> 2;
          cnt  <= cnt - 1'b1;
          if (cnt == '0) state <= DONE;
        end
        DONE: begin
          if (req.take) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign res.idle  = (state == IDLE);
  assign res.done  = (state == DONE);
  assign res.value = is_sqrt ? $signed({2'b00, root})
                   : (q_neg ? -$signed({2'b00, acc}) : $signed({2'b00, acc}));

endmodule

[sv/cqa_back.sv]
// Back end: executes queued items in two stages (operate, then finish and range
// check) into the output register. Depends on cqa_pkg and cqa_iter.
module cqa_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  cqa_pkg::item_t                head_item,
  output logic                          pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [cqa_pkg::M_TDATA_W-1:0] m_tdata,  // value [31:0], thousandths [41:32]
  output logic [cqa_pkg::M_TUSER_W-1:0] m_tuser   // status [2:0], is_negative [3]
);
  import cqa_pkg::*;

  localparam logic signed [PROD_W-1:0] MAX_V = PROD_W'(64'sd2147483647);
  localparam logic signed [PROD_W-1:0] MIN_V = -PROD_W'(64'sd2147483648);

  function automatic logic signed [WIDE_W-1:0] trunc16(input logic signed [WIDE_W-1:0] x);
    logic signed [WIDE_W-1:0] t;
    t = x[WIDE_W-1] ? x + WIDE_W'(65535) : x;
    return t >>> 16;
  endfunction

  iter_req_t ireq;
  iter_res_t ires;

  cqa_iter u_iter (
    .clk (clk),
    .rst (rst),
    .req (ireq),
    .res (ires)
  );

  // First stage registers.
  logic                      s1_v;
  kind_t                     s1_kind;
  status_t                   s1_st;
  logic signed [WIDE_W-1:0]  s1_ws;
  logic signed [PROD_W-1:0]  s1_prod;
  logic signed [DATA_W-1:0]  s1_a;
  logic                      s1_neg;
  logic [MILLI_W-1:0]        s1_milli;

  // Output registers.
  logic                      out_v;
  logic [DATA_W-1:0]         out_value;
  status_t                   out_st;
  logic                      out_neg;
  logic [MILLI_W-1:0]        out_milli;

  logic out_load;
  logic s1_free;

  assign out_load = s1_v && (!out_v || m_tready);
  assign s1_free  = !s1_v || out_load;
  assign pop      = head_valid && s1_free && (!head_item.iter || ires.done);

  assign ireq.go      = head_valid && head_item.iter && ires.idle;
  assign ireq.take    = pop && head_item.iter;
  assign ireq.is_sqrt = (head_item.op == OP_SQRT);
  assign ireq.a       = head_item.a;
  assign ireq.b       = head_item.b;

  // Operate stage.
  logic signed [WIDE_W-1:0] ae, be, t, ws_next;
  logic signed [32:0]       mx, my, mag;
  logic signed [PROD_W-1:0] prod_next;
  logic [25:0]              mp;
  kind_t                    kind_next;
  logic                     neg_next;
  logic [MILLI_W-1:0]       milli_next;

  always_comb begin
    ae         = {{(WIDE_W-DATA_W){head_item.a[31]}}, head_item.a};
    be         = {{(WIDE_W-DATA_W){head_item.b[31]}}, head_item.b};
    t          = '0;
    ws_next    = '0;
    kind_next  = KIND_PLAIN;
    neg_next   = 1'b0;
    milli_next = '0;
    mag        = head_item.a[31] ? -{head_item.a[31], head_item.a}
                                 : {head_item.a[31], head_item.a};
    mp         = 26'(mag[15:0]) * 26'd1000;
    if (head_item.op == OP_LERP) begin
      mx = 33'(be - ae);
      my = {head_item.c[31], head_item.c};
    end else begin
      mx = {head_item.a[31], head_item.a};
      my = {head_item.b[31], head_item.b};
    end
    prod_next = mx * my;
    case (head_item.op)
      OP_FROMINT:    ws_next = ae <<< 16;
      OP_TOINT:      ws_next = trunc16(ae);
      OP_TOINTROUND: begin
        t       = head_item.a[31] ? ae - WIDE_W'(32768) : ae + WIDE_W'(32768);
        ws_next = trunc16(t);
      end
      OP_PARTS: begin
        ws_next    = {{(WIDE_W-17){1'b0}}, mag[32:16]};
        milli_next = mp[25:16];
        neg_next   = head_item.a[31];
      end
      OP_ADD:   ws_next = ae + be;
      OP_SUB:   ws_next = ae - be;
      OP_MUL:   kind_next = KIND_MUL;
      OP_NEG:   ws_next = -ae;
      OP_ABS:   ws_next = head_item.a[31] ? -ae : ae;
      OP_FLOOR: ws_next = {ae[WIDE_W-1:16], 16'b0};
      OP_CEIL: begin
        t       = ae + WIDE_W'(65535);
        ws_next = {t[WIDE_W-1:16], 16'b0};
      end
      OP_ROUND: begin
        t       = head_item.a[31] ? ae - WIDE_W'(32768) : ae + WIDE_W'(32768);
        ws_next = trunc16(t) <<< 16;
      end
      OP_MIN:   ws_next = (ae < be) ? ae : be;
      OP_MAX:   ws_next = (ae > be) ? ae : be;
      OP_CLAMP: begin
        if (head_item.a < head_item.b) ws_next = be;
        else if (head_item.a > head_item.c) ws_next = {{(WIDE_W-DATA_W){head_item.c[31]}},
                                                       head_item.c};
        else ws_next = ae;
      end
      OP_LERP:  kind_next = KIND_LERP;
      OP_RATIO, OP_DIV, OP_SQRT: ws_next = ires.value;
      default:  ws_next = '0;
    endcase
    if (head_item.st != ST_OK) kind_next = KIND_PLAIN;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (pop) begin
      s1_v <= 1'b1;
    end else if (out_load) begin
      s1_v <= 1'b0;
    end
    if (pop) begin
      s1_kind  <= kind_next;
      s1_st    <= head_item.st;
      s1_ws    <= ws_next;
      s1_prod  <= prod_next;
      s1_a     <= head_item.a;
      s1_neg   <= neg_next;
      s1_milli <= milli_next;
    end
  end

  // Finish stage: scale products, add the lerp start, check the range.
  logic signed [PROD_W-1:0] pw, q, wf;
  status_t                  st_fin;

  always_comb begin
    pw = s1_prod[PROD_W-1] ? s1_prod + PROD_W'(65535) : s1_prod;
    q  = pw >>> 16;
    case (s1_kind)
      KIND_MUL:  wf = q;
      KIND_LERP: wf = q + {{(PROD_W-DATA_W){s1_a[31]}}, s1_a};
      default:   wf = {{(PROD_W-WIDE_W){s1_ws[WIDE_W-1]}}, s1_ws};
    endcase
    st_fin = s1_st;
    if (s1_st == ST_OK) begin
      if (wf > MAX_V) st_fin = ST_OVER;
      else if (wf < MIN_V) st_fin = ST_UNDER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (out_load) begin
      out_v <= 1'b1;
    end else if (m_tready) begin
      out_v <= 1'b0;
    end
    if (out_load) begin
      out_st    <= st_fin;
      out_value <= (st_fin == ST_OK) ? wf[DATA_W-1:0] : '0;
      out_neg   <= (st_fin == ST_OK) ? s1_neg : 1'b0;
      out_milli <= (st_fin == ST_OK) ? s1_milli : '0;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = {{(M_TDATA_W-DATA_W-MILLI_W){1'b0}}, out_milli, out_value};
  assign m_tuser  = {out_neg, out_st};

endmodule

[sv/cqa_checker.sv]
// Port-level checks for the checked Q16.16 arithmetic unit, bound to the top level.
// Depends on cqa_pkg and checked_q16_16_fixed_alu.
module cqa_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [cqa_pkg::S_TDATA_W-1:0] s_tdata,
  input logic [cqa_pkg::S_TUSER_W-1:0] s_tuser,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [cqa_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [cqa_pkg::M_TUSER_W-1:0] m_tuser
);
  import cqa_pkg::*;

  // A stalled result beat holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // No result leaves right after reset.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // An error status carries a zero value, sign and fraction.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2:0] != ST_OK |-> m_tdata[41:0] == '0 && !m_tuser[3])
    else $error("error result with nonzero payload");

  // Thousandths stay below one thousand and the status is one of the defined codes.
  a_milli: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[41:32] < 10'd1000 && m_tuser[2:0] < 3'd6)
    else $error("thousandths or status out of range");

endmodule

bind checked_q16_16_fixed_alu cqa_checker u_cqa_checker (.*);

[sim/tb_checked_q16_16_fixed_alu.sv]
// Self-checking testbench for the checked Q16.16 arithmetic unit.
// Depends on cqa_pkg and checked_q16_16_fixed_alu; predicts every result beat in a scoreboard.
`timescale 1ns / 100ps

module tb_checked_q16_16_fixed_alu;
  import cqa_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_ITEMS   = 400;

  // One predicted result beat.
  typedef struct {
    logic [31:0] value;
    logic [2:0]  status;
    logic        neg;
    logic [9:0]  milli;
  } alu_result_t;

  // Holds the predicted results in order and compares arriving beats with them.
  class alu_scoreboard;
    alu_result_t pending[$];
    int          errors;

    function new();
      errors = 0;
    endfunction

    // Largest r with r*r <= v; v stays below 2^47, so 24 result bits suffice.
    function automatic longint unsigned isqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int i = 23; i >= 0; i--) begin
        t = r | (64'd1 << i);
        if (t * t <= v) r = t;
      end
      return isqrt_done(r);
    endfunction

    function automatic longint unsigned isqrt_done(longint unsigned r);
      return r;
    endfunction

    // Computes the result of one operation with wide intermediates.
    function automatic alu_result_t compute(logic [4:0] op, logic signed [31:0] a32,
                                            logic signed [31:0] b32, logic signed [31:0] c32);
      alu_result_t res;
      longint      a, b, c, w, m;
      status_t     st;
      logic        neg;
      longint      milli;
      a = a32; b = b32; c = c32;
      w = 0; st = ST_OK; neg = 0; milli = 0;
      case (op)
        OP_FROMINT: begin
          if (a > 32767) st = ST_OVER;
          else if (a < -32768) st = ST_UNDER;
          else w = a * 65536;
        end
        OP_RATIO, OP_DIV: begin
          if (b == 0) st = ST_DIVZ;
          else w = (a * 65536) / b;
        end
        OP_TOINT: w = a / 65536;
        OP_TOINTROUND: w = ((a >= 0) ? a + 32768 : a - 32768) / 65536;
        OP_PARTS: begin
          m = a;
          if (m < 0) begin
            m = -m;
            neg = 1;
          end
          w = m / 65536;
          milli = ((m % 65536) * 1000) / 65536;
        end
        OP_ADD: w = a + b;
        OP_SUB: w = a - b;
        OP_MUL: w = (a * b) / 65536;
        OP_NEG: w = -a;
        OP_ABS: w = (a < 0) ? -a : a;
        OP_FLOOR: begin
          w = (a / 65536) * 65536;
          if (a < 0 && (a % 65536) != 0) w -= 65536;
        end
        OP_CEIL: begin
          w = (a / 65536) * 65536;
          if (a > 0 && (a % 65536) != 0) w += 65536;
        end
        OP_ROUND: w = (((a >= 0) ? a + 32768 : a - 32768) / 65536) * 65536;
        OP_MIN: w = (a < b) ? a : b;
        OP_MAX: w = (a > b) ? a : b;
        OP_CLAMP: begin
          if (b > c) st = ST_RANGE;
          else w = (a < b) ? b : ((a > c) ? c : a);
        end
        OP_LERP: begin
          if (c < 0 || c > 65536) st = ST_RANGE;
          else w = a + ((b - a) * c) / 65536;
        end
        OP_SQRT: begin
          if (a < 0) st = ST_DOMAIN;
          else w = longint'(isqrt(longint'(a) * 65536));
        end
        default: st = ST_DOMAIN;
      endcase
      // Anything outside 32 signed bits is reported and zeroed.
      if (st == ST_OK) begin
        if (w > 64'sd2147483647) st = ST_OVER;
        else if (w < -64'sd2147483648) st = ST_UNDER;
      end
      if (st != ST_OK) begin
        w = 0; neg = 0; milli = 0;
      end
      res.value  = w[31:0];
      res.status = st;
      res.neg    = neg;
      res.milli  = milli[9:0];
      return res;
    endfunction

    function void note_operation(logic [4:0] op, logic [31:0] a, logic [31:0] b,
                                 logic [31:0] c);
      pending.push_back(compute(op, a, b, c));
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] tdata, logic [M_TUSER_W-1:0] tuser);
      alu_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat tdata=%h tuser=%h", $time, tdata, tuser);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (tdata[31:0] !== exp_r.value) begin
        $display("%0t: value expected %h actual %h", $time, exp_r.value, tdata[31:0]);
        errors++;
      end
      if (tdata[41:32] !== exp_r.milli) begin
        $display("%0t: thousandths expected %0d actual %0d", $time, exp_r.milli,
                 tdata[41:32]);
        errors++;
      end
      if (tuser[2:0] !== exp_r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_r.status, tuser[2:0]);
        errors++;
      end
      if (tuser[3] !== exp_r.neg) begin
        $display("%0t: is_negative expected %b actual %b", $time, exp_r.neg, tuser[3]);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic [S_TUSER_W-1:0] s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [M_TUSER_W-1:0] m_tuser;

  alu_scoreboard board;
  logic          steady;      // no idling on either side while set
  logic          hold_req;    // asks the receiver for a long stall
  int            quiet_cycles;

  checked_q16_16_fixed_alu u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Scoreboard traffic and the watchdog, all sampled at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        board.note_operation(s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[95:64]);
      if (m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus one long hold on request.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready = steady || ($urandom_range(99) >= 33);
      end
    end
  end

  // Offers one beat, idling at random first, and returns once it is accepted.
  task automatic send_op(logic [4:0] op, logic [31:0] a, logic [31:0] b, logic [31:0] c);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 33) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = {c, b, a};
    do @(posedge clk); while (!s_tready);
  endtask

  // Draws an operand: extremes, small Q16.16 values, or full range.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2, 3: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
      4: return $urandom_range(65536);
      5: return $urandom_range(100000) - 50000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random();
    logic [4:0] op;
    op = ($urandom_range(19) == 0) ? 5'($urandom_range(31, 19)) : 5'($urandom_range(18));
    send_op(op, pick_operand(), pick_operand(), pick_operand());
  endtask

  initial begin
    board        = new();
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = '0;
    steady       = 1'b0;
    hold_req     = 1'b0;
    quiet_cycles = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: range limits of fromint, zero divisors, most negative values,
    // rounding halves, reversed clamp, lerp position limits, negative root.
    send_op(OP_FROMINT, 32'd32767, 0, 0);
    send_op(OP_FROMINT, 32'd32768, 0, 0);
    send_op(OP_FROMINT, -32'sd32768, 0, 0);
    send_op(OP_FROMINT, -32'sd32769, 0, 0);
    send_op(OP_RATIO, 32'd7, 0, 0);
    send_op(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 0);
    send_op(OP_DIV, 32'h0001_0000, 0, 0);
    send_op(OP_NEG, 32'h8000_0000, 0, 0);
    send_op(OP_ABS, 32'h8000_0000, 0, 0);
    send_op(OP_PARTS, 32'h8000_0000, 0, 0);
    send_op(OP_PARTS, 32'hFFFE_8000, 0, 0);
    send_op(OP_TOINTROUND, 32'h0000_8000, 0, 0);
    send_op(OP_TOINTROUND, 32'hFFFF_8000, 0, 0);
    send_op(OP_ROUND, 32'h7FFF_FFFF, 0, 0);
    send_op(OP_ROUND, 32'hFFFE_8000, 0, 0);
    send_op(OP_CLAMP, 32'd5, 32'd9, 32'd3);
    send_op(OP_LERP, 32'd0, 32'h0010_0000, 32'h0001_0001);
    send_op(OP_LERP, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_op(OP_LERP, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000);
    send_op(OP_SQRT, 32'hFFFF_FFFF, 0, 0);
    send_op(OP_SQRT, 32'h7FFF_FFFF, 0, 0);
    send_op(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send_op(OP_ADD, 32'h7FFF_FFFF, 32'd1, 0);
    send_op(OP_SUB, 32'h8000_0000, 32'd1, 0);
    send_op(5'd31, 0, 0, 0);

    // Random phase, with a steady stretch and one long receiver hold.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady = (i >= 100 && i < 180);
      if (i == 220) hold_req = 1'b1;
      send_random();
    end
    @(negedge clk);
    s_tvalid = 1'b0;
    steady   = 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (board.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
